// ----- hdl/ccp_pkg.sv -----
package ccp_pkg;

	typedef struct packed {
		logic               key_down;
		logic               scene_ready;
		logic signed [31:0] head_x;
		logic signed [31:0] head_y;
		logic signed [31:0] head_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} ccp_req_t;

	typedef struct packed {
		logic signed [31:0] cam_pos_x;
		logic signed [31:0] cam_pos_y;
		logic signed [31:0] cam_pos_z;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] fwd_x;
		logic signed [15:0] fwd_y;
		logic signed [15:0] fwd_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} ccp_rsp_t;

	typedef enum logic [1:0] {
		CFG_ENABLE,
		CFG_DIST,
		CFG_HEIGHT,
		CFG_SIDE
	} ccp_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MWAIT,
		ST_SQ,
		ST_SQWAIT,
		ST_SQRT,
		ST_SQRTWAIT,
		ST_DIV,
		ST_DIVWAIT,
		ST_RSET,
		ST_OUT
	} ccp_state_t;

	typedef enum logic [1:0] {
		TGT_F,
		TGT_R,
		TGT_U
	} ccp_tgt_t;

	typedef enum logic [3:0] {
		SRC_QW, SRC_QX, SRC_QY, SRC_QZ,
		SRC_F0, SRC_F1, SRC_F2,
		SRC_R0, SRC_R1, SRC_R2,
		SRC_U0, SRC_U1, SRC_U2,
		SRC_DIST, SRC_HGT, SRC_SIDE
	} ccp_src_t;

	typedef enum logic [1:0] {
		DST_NONE,
		DST_FWD,
		DST_UP,
		DST_POS
	} ccp_dst_t;

	typedef struct packed {
		ccp_src_t   a;
		ccp_src_t   b;
		logic       neg;
		ccp_dst_t   dst;
		logic [1:0] comp;
	} ccp_op_t;

	localparam int OneQ14 = 16384;
	localparam int MulDigitW = 4;
	localparam int MulSteps = 32 / MulDigitW;
	localparam int SqrtSteps = 30;
	localparam int DivSteps = 15;

	localparam logic [4:0] OP_FWD_LAST = 5'd5;
	localparam logic [4:0] OP_BIAS = 5'd2;
	localparam logic [4:0] OP_UP_LAST = 5'd11;
	localparam logic [4:0] OP_POS_LAST = 5'd20;
	localparam logic signed [63:0] FWD_BIAS = 64'sd134217728;

	function automatic ccp_op_t op_of(input logic [4:0] idx);
		ccp_op_t o;
		unique case (idx)
			5'd0:  o = '{SRC_QX, SRC_QY, 1'b0, DST_NONE, 2'd0};
			5'd1:  o = '{SRC_QW, SRC_QZ, 1'b1, DST_FWD, 2'd0};
			5'd2:  o = '{SRC_QX, SRC_QX, 1'b1, DST_NONE, 2'd1};
			5'd3:  o = '{SRC_QZ, SRC_QZ, 1'b1, DST_FWD, 2'd1};
			5'd4:  o = '{SRC_QY, SRC_QZ, 1'b0, DST_NONE, 2'd2};
			5'd5:  o = '{SRC_QW, SRC_QX, 1'b0, DST_FWD, 2'd2};
			5'd6:  o = '{SRC_F1, SRC_R2, 1'b0, DST_NONE, 2'd0};
			5'd7:  o = '{SRC_F2, SRC_R1, 1'b1, DST_UP, 2'd0};
			5'd8:  o = '{SRC_F2, SRC_R0, 1'b0, DST_NONE, 2'd1};
			5'd9:  o = '{SRC_F0, SRC_R2, 1'b1, DST_UP, 2'd1};
			5'd10: o = '{SRC_F0, SRC_R1, 1'b0, DST_NONE, 2'd2};
			5'd11: o = '{SRC_F1, SRC_R0, 1'b1, DST_UP, 2'd2};
			5'd12: o = '{SRC_DIST, SRC_F0, 1'b1, DST_NONE, 2'd0};
			5'd13: o = '{SRC_HGT, SRC_U0, 1'b0, DST_NONE, 2'd0};
			5'd14: o = '{SRC_SIDE, SRC_R0, 1'b0, DST_POS, 2'd0};
			5'd15: o = '{SRC_DIST, SRC_F1, 1'b1, DST_NONE, 2'd1};
			5'd16: o = '{SRC_HGT, SRC_U1, 1'b0, DST_NONE, 2'd1};
			5'd17: o = '{SRC_SIDE, SRC_R1, 1'b0, DST_POS, 2'd1};
			5'd18: o = '{SRC_DIST, SRC_F2, 1'b1, DST_NONE, 2'd2};
			5'd19: o = '{SRC_HGT, SRC_U2, 1'b0, DST_NONE, 2'd2};
			5'd20: o = '{SRC_SIDE, SRC_R2, 1'b0, DST_POS, 2'd2};
			default: o = '{SRC_QW, SRC_QW, 1'b0, DST_NONE, 2'd0};
		endcase
		return o;
	endfunction

endpackage

// ----- hdl/ccp_mul.sv -----
module ccp_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic               neg,
	output logic               done,
	output logic signed [63:0] prod
);
	import ccp_pkg::*;

	logic [31:0] a_mag_q;
	logic [31:0] b_q;
	logic [63:0] p_q;
	logic        neg_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] pp;
	logic [67:0] sum;

	assign pp = 36'(a_mag_q) * 36'(b_q[MulDigitW-1:0]);
	assign sum = {4'd0, p_q} + {pp, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(MulSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_mag_q <= a[31] ? 32'(-a) : 32'(a);
			b_q     <= b[31] ? 32'(-b) : 32'(b);
			p_q     <= '0;
			neg_q   <= a[31] ^ b[31] ^ neg;
		end else if (busy_q) begin
			p_q <= sum[67:4];
			b_q <= b_q >> MulDigitW;
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed(p_q) : $signed(p_q);
endmodule

// ----- hdl/ccp_sqrt.sv -----
module ccp_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [59:0] s,
	output logic        done,
	output logic [29:0] root
);
	import ccp_pkg::*;

	logic [59:0] s_q;
	logic [32:0] rem_q;
	logic [29:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] t;
	logic [34:0] trial;

	assign t = {rem_q, s_q[59:58]};
	assign trial = {3'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SqrtSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= s;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			s_q <= {s_q[57:0], 2'b00};
			if (t >= trial) begin
				rem_q  <= 33'(t - trial);
				root_q <= {root_q[28:0], 1'b1};
			end else begin
				rem_q  <= t[32:0];
				root_q <= {root_q[28:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ----- hdl/ccp_div.sv -----
module ccp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] m,
	input  logic [29:0] d,
	output logic        done,
	output logic [14:0] q
);
	import ccp_pkg::*;

	logic [29:0] d_q;
	logic [29:0] r_q;
	logic [14:0] n_q;
	logic [14:0] q_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [44:0] num;
	logic [30:0] t;

	assign num = {m, 14'd0} + 45'(d >> 1);
	assign t = {r_q, n_q[14]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
			r_q <= num[44:15];
			n_q <= num[14:0];
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[13:0], 1'b0};
			if (t >= {1'b0, d_q}) begin
				r_q <= 30'(t - {1'b0, d_q});
				q_q <= {q_q[13:0], 1'b1};
			end else begin
				r_q <= t[29:0];
				q_q <= {q_q[13:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q = q_q;
endmodule

// ----- hdl/chase_camera_pose_core.sv -----
// Chase camera pose core.
// Request channel (req_valid / req_stall / req): one frame per request. A rising
// edge of key_down toggles the view flag on every accepted request. When the
// camera is enabled, the view is active and scene_ready is set, the request
// yields one pose on the response channel (rsp_valid / rsp_stall / rsp);
// otherwise it yields nothing and the core is ready again next cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index (enable, follow
// distance, height offset, side offset); write only while idle.
// Sequencing: each of the 30 products runs through a radix-16 serial multiplier;
// the three square roots and the nine quotients are computed as well, all one
// after the other. A new request is taken once the pose is moved to the response
// register.
// Reset clears the view flag and key history and loads the register defaults
// (disabled, distance 768, zero offsets); no response is pending.
// A stalled response holds; the core accepts the next request meanwhile and
// waits before its own result if the response register is still full.
module chase_camera_pose_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ccp_pkg::ccp_req_t   req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ccp_pkg::ccp_rsp_t   rsp,
	input  logic                cfg_we,
	input  ccp_pkg::ccp_cfg_t   cfg_index,
	input  logic [15:0]         cfg_data
);
	import ccp_pkg::*;

	ccp_state_t state_q, state_d;
	ccp_tgt_t   tgt_q;
	logic [4:0] op_q;
	logic [1:0] k_q;

	logic               enable_q;
	logic [14:0]        dist_q;
	logic signed [15:0] height_q;
	logic signed [15:0] side_q;
	logic               view_active_q;
	logic               key_was_down_q;

	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0] head_q [3];
	logic signed [30:0] v_q [3];
	logic signed [15:0] f_q [3];
	logic signed [15:0] rt_q [3];
	logic signed [15:0] up_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [63:0] acc_q;
	logic [29:0]        r_q;

	ccp_rsp_t rsp_q;
	logic     rsp_valid_q;

	logic               accept;
	logic               new_active;
	logic               produce;
	logic               rsp_free;
	ccp_op_t            op;
	logic signed [31:0] mul_a, mul_b;
	logic               mul_neg;
	logic               mul_start, mul_done;
	logic signed [63:0] prod;
	logic signed [63:0] acc_sum;
	logic               sqrt_start, sqrt_done;
	logic [29:0]        root;
	logic               div_start, div_done;
	logic [30:0]        div_m;
	logic [14:0]        quo;
	logic signed [15:0] nval;
	logic signed [63:0] rnd;
	logic signed [32:0] pos_sum;
	logic signed [31:0] pos_sat;

	assign accept = req_valid && !req_stall;
	assign new_active = view_active_q ^ (req.key_down && !key_was_down_q);
	assign produce = enable_q && new_active && req.scene_ready;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign op = op_of(op_q);
	assign acc_sum = acc_q + prod;

	function automatic logic signed [31:0] src_val(input ccp_src_t s,
		input logic signed [15:0] qw, input logic signed [15:0] qx,
		input logic signed [15:0] qy, input logic signed [15:0] qz,
		input logic signed [15:0] f0, input logic signed [15:0] f1,
		input logic signed [15:0] f2, input logic signed [15:0] r0,
		input logic signed [15:0] r1, input logic signed [15:0] r2,
		input logic signed [15:0] u0, input logic signed [15:0] u1,
		input logic signed [15:0] u2, input logic [14:0] fdist,
		input logic signed [15:0] hgt, input logic signed [15:0] side);
		logic signed [15:0] v16;
		v16 = '0;
		case (s)
			SRC_QW:   v16 = qw;
			SRC_QX:   v16 = qx;
			SRC_QY:   v16 = qy;
			SRC_QZ:   v16 = qz;
			SRC_F0:   v16 = f0;
			SRC_F1:   v16 = f1;
			SRC_F2:   v16 = f2;
			SRC_R0:   v16 = r0;
			SRC_R1:   v16 = r1;
			SRC_R2:   v16 = r2;
			SRC_U0:   v16 = u0;
			SRC_U1:   v16 = u1;
			SRC_U2:   v16 = u2;
			SRC_DIST: v16 = $signed({1'b0, fdist});
			SRC_HGT:  v16 = hgt;
			SRC_SIDE: v16 = side;
			default:  v16 = '0;
		endcase
		return 32'(v16);
	endfunction

	always_comb begin
		if (state_q == ST_SQ) begin
			mul_a   = 32'(v_q[k_q]);
			mul_b   = 32'(v_q[k_q]);
			mul_neg = 1'b0;
		end else begin
			mul_a = src_val(op.a, qw_q, qx_q, qy_q, qz_q, f_q[0], f_q[1], f_q[2],
				rt_q[0], rt_q[1], rt_q[2], up_q[0], up_q[1], up_q[2],
				dist_q, height_q, side_q);
			mul_b = src_val(op.b, qw_q, qx_q, qy_q, qz_q, f_q[0], f_q[1], f_q[2],
				rt_q[0], rt_q[1], rt_q[2], up_q[0], up_q[1], up_q[2],
				dist_q, height_q, side_q);
			mul_neg = op.neg;
		end
	end

	assign div_m = v_q[k_q][30] ? 31'(-v_q[k_q]) : 31'(v_q[k_q]);
	assign nval = (r_q == '0) ? 16'sd0 :
		(v_q[k_q][30] ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));

	assign rnd = (acc_sum + 64'sd8192) >>> 14;
	assign pos_sum = 33'(head_q[op.comp]) + 33'(rnd);
	assign pos_sat = (pos_sum[32] != pos_sum[31]) ?
		(pos_sum[32] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}})) :
		pos_sum[31:0];

	ccp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.neg    (mul_neg),
		.done   (mul_done),
		.prod   (prod)
	);

	ccp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.s      (acc_q[59:0]),
		.done   (sqrt_done),
		.root   (root)
	);

	ccp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.m      (div_m),
		.d      (r_q),
		.done   (div_done),
		.q      (quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept && produce) state_d = ST_MUL;
			ST_MUL:      state_d = ST_MWAIT;
			ST_MWAIT: begin
				if (mul_done) begin
					if (op_q == OP_FWD_LAST || op_q == OP_UP_LAST) state_d = ST_SQ;
					else if (op_q == OP_POS_LAST) state_d = ST_OUT;
					else state_d = ST_MUL;
				end
			end
			ST_SQ:       state_d = ST_SQWAIT;
			ST_SQWAIT:   if (mul_done) state_d = (k_q == 2'd2) ? ST_SQRT : ST_SQ;
			ST_SQRT:     state_d = ST_SQRTWAIT;
			ST_SQRTWAIT: if (sqrt_done) state_d = ST_DIV;
			ST_DIV:      state_d = ST_DIVWAIT;
			ST_DIVWAIT: begin
				if (div_done) begin
					if (k_q != 2'd2) state_d = ST_DIV;
					else if (tgt_q == TGT_F) state_d = ST_RSET;
					else state_d = ST_MUL;
				end
			end
			ST_RSET:     state_d = ST_SQ;
			ST_OUT:      if (rsp_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		mul_start  = (state_q == ST_MUL) || (state_q == ST_SQ);
		sqrt_start = (state_q == ST_SQRT);
		div_start  = (state_q == ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tgt_q          <= TGT_F;
			op_q           <= '0;
			k_q            <= '0;
			enable_q       <= 1'b0;
			dist_q         <= 15'd768;
			height_q       <= '0;
			side_q         <= '0;
			view_active_q  <= 1'b0;
			key_was_down_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENABLE: enable_q <= cfg_data[0];
					CFG_DIST:   dist_q   <= cfg_data[14:0];
					CFG_HEIGHT: height_q <= $signed(cfg_data);
					CFG_SIDE:   side_q   <= $signed(cfg_data);
					default:    ;
				endcase
			end
			if (accept) begin
				view_active_q  <= new_active;
				key_was_down_q <= req.key_down;
				op_q           <= '0;
				k_q            <= '0;
			end
			if (state_q == ST_MWAIT && mul_done) begin
				op_q <= op_q + 5'd1;
				if (op_q == OP_FWD_LAST) tgt_q <= TGT_F;
				if (op_q == OP_UP_LAST) tgt_q <= TGT_U;
			end
			if ((state_q == ST_SQWAIT && mul_done) || (state_q == ST_DIVWAIT && div_done))
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			if (state_q == ST_RSET) tgt_q <= TGT_R;
			if (state_q == ST_OUT && rsp_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			acc_q     <= '0;
			head_q[0] <= req.head_x;
			head_q[1] <= req.head_y;
			head_q[2] <= req.head_z;
			qx_q      <= req.quat_x;
			qy_q      <= req.quat_y;
			qz_q      <= req.quat_z;
			if (req.quat_w == '0 && req.quat_x == '0 && req.quat_y == '0 &&
				req.quat_z == '0)
				qw_q <= 16'(OneQ14);
			else
				qw_q <= req.quat_w;
		end
		if (state_q == ST_MWAIT && mul_done) begin
			if (op.dst != DST_NONE)
				acc_q <= (op_q + 5'd1 == OP_BIAS) ? FWD_BIAS : 64'sd0;
			else
				acc_q <= acc_sum;
			case (op.dst)
				DST_FWD: v_q[op.comp] <= 31'(acc_sum >>> 3);
				DST_UP:  v_q[op.comp] <= 31'(acc_sum);
				DST_POS: pos_q[op.comp] <= pos_sat;
				default: ;
			endcase
		end
		if (state_q == ST_SQWAIT && mul_done) acc_q <= acc_sum;
		if (state_q == ST_SQRTWAIT && sqrt_done) begin
			r_q   <= root;
			acc_q <= '0;
		end
		if (state_q == ST_DIVWAIT && div_done) begin
			case (tgt_q)
				TGT_F:   f_q[k_q]  <= nval;
				TGT_R:   rt_q[k_q] <= nval;
				default: up_q[k_q] <= nval;
			endcase
		end
		if (state_q == ST_RSET) begin
			v_q[0] <= -(31'(f_q[1]) <<< 14);
			v_q[1] <= 31'(f_q[0]) <<< 14;
			v_q[2] <= '0;
		end
		if (state_q == ST_OUT && rsp_free) begin
			rsp_q.cam_pos_x <= pos_q[0];
			rsp_q.cam_pos_y <= pos_q[1];
			rsp_q.cam_pos_z <= pos_q[2];
			rsp_q.right_x   <= rt_q[0];
			rsp_q.right_y   <= rt_q[1];
			rsp_q.right_z   <= rt_q[2];
			rsp_q.fwd_x     <= f_q[0];
			rsp_q.fwd_y     <= f_q[1];
			rsp_q.fwd_z     <= f_q[2];
			rsp_q.up_x      <= up_q[0];
			rsp_q.up_y      <= up_q[1];
			rsp_q.up_z      <= up_q[2];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule
